// File: design/dir_record_stream_parser_macros.svh
// Assertion helpers used by the directory record parser module.
`ifndef DIR_RECORD_STREAM_PARSER_MACROS_SVH
`define DIR_RECORD_STREAM_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dir_record_stream_parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DRSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dir_record_stream_parser: next-cycle check failed");

`endif

// File: design/drsp_pkg.sv
`default_nettype none

package drsp_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_NAME     = 2'd1,
    KIND_OVERFLOW = 2'd2,
    KIND_BAD_LEN  = 2'd3
  } kind_t;

  // Byte positions inside a record header.
  localparam logic [15:0] OFF_SPAN_LO  = 16'd4;
  localparam logic [15:0] OFF_SPAN_HI  = 16'd5;
  localparam logic [15:0] OFF_NAME_LEN = 16'd6;
  localparam logic [15:0] OFF_TYPE     = 16'd7;
  localparam logic [15:0] HEADER_BYTES = 16'd8;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  entry_index;
    logic [31:0] entry_inode;
    logic [7:0]  name_len;
    logic [7:0]  type_code;
    logic [7:0]  name_char;
    logic [7:0]  char_position;
  } result_t;

endpackage

`default_nettype wire

// File: design/drsp_decode.sv
`default_nettype none

module drsp_decode #(
  parameter int MAX_ENTRIES = 64,
  parameter int CNT_W       = 7
) (
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_of_directory,
  input  wire logic [15:0]      record_offset,
  input  wire logic [15:0]      record_span,
  input  wire logic [31:0]      inode_accum,
  input  wire logic [7:0]       held_name_len,
  input  wire logic [CNT_W-1:0] entry_count,
  input  wire logic             stopped,
  output logic [15:0]           record_offset_next,
  output logic [15:0]           record_span_next,
  output logic [31:0]           inode_accum_next,
  output logic [7:0]            held_name_len_next,
  output logic [CNT_W-1:0]      entry_count_next,
  output logic                  stopped_next,
  output logic                  res_valid,
  output drsp_pkg::result_t     res
);

  logic [CNT_W+5:0] count_wide;
  logic [CNT_W+5:0] count_less_wide;
  logic [16:0]      off_inc;
  logic [15:0]      name_pos;
  logic             advance;
  logic             full;

  assign count_wide      = {6'd0, entry_count};
  assign count_less_wide = {6'd0, entry_count - CNT_W'(1)};
  assign full            = entry_count >= CNT_W'(MAX_ENTRIES);
  assign off_inc         = {1'b0, record_offset} + 17'd1;
  assign name_pos        = record_offset - drsp_pkg::HEADER_BYTES;

  always_comb begin
    record_offset_next = record_offset;
    record_span_next   = record_span;
    inode_accum_next   = inode_accum;
    held_name_len_next = held_name_len;
    entry_count_next   = entry_count;
    stopped_next       = stopped;
    res_valid          = 1'b0;
    res                = '0;
    advance            = 1'b1;

    if (!stopped) begin
      if (record_offset == 16'd0 && full) begin
        res.kind     = drsp_pkg::KIND_OVERFLOW;
        res_valid    = 1'b1;
        stopped_next = 1'b1;
        advance      = 1'b0;
      end else if (record_offset < drsp_pkg::OFF_SPAN_LO) begin
        case (record_offset[1:0])
          2'd0:    inode_accum_next[7:0]   = data_byte;
          2'd1:    inode_accum_next[15:8]  = data_byte;
          2'd2:    inode_accum_next[23:16] = data_byte;
          default: inode_accum_next[31:24] = data_byte;
        endcase
      end else if (record_offset == drsp_pkg::OFF_SPAN_LO) begin
        record_span_next[7:0] = data_byte;
      end else if (record_offset == drsp_pkg::OFF_SPAN_HI) begin
        record_span_next[15:8] = data_byte;
      end else if (record_offset == drsp_pkg::OFF_NAME_LEN) begin
        held_name_len_next = data_byte;
      end else if (record_offset == drsp_pkg::OFF_TYPE) begin
        res_valid = 1'b1;
        if (record_span < drsp_pkg::HEADER_BYTES) begin
          res.kind     = drsp_pkg::KIND_BAD_LEN;
          stopped_next = 1'b1;
          advance      = 1'b0;
        end else begin
          res.kind        = drsp_pkg::KIND_HEADER;
          res.entry_index = count_wide[5:0];
          res.entry_inode = inode_accum;
          res.name_len    = held_name_len;
          res.type_code   = data_byte;
          if (!full) begin
            entry_count_next = entry_count + CNT_W'(1);
          end
        end
      end else if (name_pos < {8'd0, held_name_len}) begin
        // Name bytes past the record length never get here: the offset wraps first.
        res_valid         = 1'b1;
        res.kind          = drsp_pkg::KIND_NAME;
        res.entry_index   = count_less_wide[5:0];
        res.name_char     = data_byte;
        res.char_position = name_pos[7:0];
      end

      if (advance) begin
        if (off_inc >= {1'b0, drsp_pkg::HEADER_BYTES} && off_inc >= {1'b0, record_span}) begin
          record_offset_next = 16'd0;
        end else begin
          record_offset_next = off_inc[15:0];
        end
      end
    end

    if (last_of_directory) begin
      record_offset_next = '0;
      record_span_next   = '0;
      inode_accum_next   = '0;
      held_name_len_next = '0;
      entry_count_next   = '0;
      stopped_next       = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: design/dir_record_stream_parser.sv
// Directory record parser: takes directory data one byte per request on the
// input channel (data_byte, last_of_directory) and splits it into records.
// Byte 7 of each record yields a header result (kind 0), every name byte yields
// a name result (kind 1), and padding yields nothing. Too many entries (kind 2)
// or a record length below 8 (kind 3) yields one error result, after which
// bytes are dropped until the byte marked last_of_directory.
// Each accepted byte produces zero or one result. A result appears on the
// output channel in the cycle after its byte is accepted; the parse state and the
// result register are both loaded from the same combinational decode, so one byte can
// be taken every cycle while in_stall is low.
// in_stall is high only while a held result is stalled by out_stall, so a
// stalled output blocks the input and nothing is lost or repeated.
// The byte marked last_of_directory is parsed as usual and then all record
// state clears for the next directory.
// A synchronous reset clears the parse state and empties the output register.
`default_nettype none

module dir_record_stream_parser #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_of_directory,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [5:0]       entry_index,
  output logic [31:0]      entry_inode,
  output logic [7:0]       name_len,
  output logic [7:0]       type_code,
  output logic [7:0]       name_char,
  output logic [7:0]       char_position
);

`include "dir_record_stream_parser_macros.svh"

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [15:0]       record_offset;
  logic [15:0]       record_span;
  logic [31:0]       inode_accum;
  logic [7:0]        held_name_len;
  logic [CNT_W-1:0]  entry_count;
  logic              stopped;

  logic [15:0]       record_offset_next;
  logic [15:0]       record_span_next;
  logic [31:0]       inode_accum_next;
  logic [7:0]        held_name_len_next;
  logic [CNT_W-1:0]  entry_count_next;
  logic              stopped_next;

  logic              res_valid;
  drsp_pkg::result_t res;
  drsp_pkg::result_t out_res;
  logic              in_accept;
  logic              out_is_error;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  drsp_decode #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .CNT_W       (CNT_W)
  ) u_decode (
    .data_byte          (data_byte),
    .last_of_directory  (last_of_directory),
    .record_offset      (record_offset),
    .record_span        (record_span),
    .inode_accum        (inode_accum),
    .held_name_len      (held_name_len),
    .entry_count        (entry_count),
    .stopped            (stopped),
    .record_offset_next (record_offset_next),
    .record_span_next   (record_span_next),
    .inode_accum_next   (inode_accum_next),
    .held_name_len_next (held_name_len_next),
    .entry_count_next   (entry_count_next),
    .stopped_next       (stopped_next),
    .res_valid          (res_valid),
    .res                (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      record_offset <= '0;
      record_span   <= '0;
      inode_accum   <= '0;
      held_name_len <= '0;
      entry_count   <= '0;
      stopped       <= 1'b0;
    end else if (in_accept) begin
      record_offset <= record_offset_next;
      record_span   <= record_span_next;
      inode_accum   <= inode_accum_next;
      held_name_len <= held_name_len_next;
      entry_count   <= entry_count_next;
      stopped       <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_res <= res;
    end
  end

  assign kind          = out_res.kind;
  assign entry_index   = out_res.entry_index;
  assign entry_inode   = out_res.entry_inode;
  assign name_len      = out_res.name_len;
  assign type_code     = out_res.type_code;
  assign name_char     = out_res.name_char;
  assign char_position = out_res.char_position;

  assign out_is_error = out_valid && (out_res.kind == drsp_pkg::KIND_OVERFLOW ||
                                      out_res.kind == drsp_pkg::KIND_BAD_LEN);

  `DRSP_ASSERT_NOW(a_count_bounded, 1'b1, entry_count <= CNT_W'(MAX_ENTRIES))
  `DRSP_ASSERT_NOW(a_offset_in_record, record_offset >= 16'd8, record_offset < record_span)
  `DRSP_ASSERT_NEXT(a_stopped_silent, in_accept && stopped, !out_valid)
  `DRSP_ASSERT_NOW(a_error_fields_clear, out_is_error, entry_index == 6'd0 && entry_inode == 32'd0)

endmodule

`default_nettype wire
